@@ design/psf_pkg.sv @@
package psf_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam int VALUE_W     = 32;
    localparam int COMP_W      = VALUE_W + 1;

    // power of two so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int OUT_DATA_W  = ((VALUE_W + COMP_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    typedef struct packed {
        logic               last;
        logic [VALUE_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic               found;
        logic               overflow;
        logic [VALUE_W-1:0] first_value;
        logic [COMP_W-1:0]  second_value;
    } t_result;

endpackage

@@ design/pair_sum_finder_unit.sv @@
// Two-sum search. Items (signed 32-bit values) are loaded one per cycle, while
// the block is in its load state, into a 64-entry store with one write and one
// read port through a four-item input queue; the item with tlast ends the data
// set and starts the search. For each stored value x in load order the block
// forms target - x at 33 bits and, where that complement is in 32-bit range
// and differs from x, walks the store reading one entry a cycle to look for it.
// The scan is bound by the single read port of the store; input is not taken
// from the queue meanwhile. One result item follows each last item; items
// beyond capacity are dropped and flagged in the result. The target is written
// through the configuration port and is read during the search.
module pair_sum_finder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [psf_pkg::VALUE_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] value
    input  logic [psf_pkg::VALUE_W-1:0]     i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] first_value, [64:32] second_value, [71:65] zero
    output logic [psf_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] found, [1] overflow
    output logic [psf_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);
    import psf_pkg::*;

    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    q_ready;
    t_result res;

    assign in_item.value = i_s_axis_tdata;
    assign in_item.last  = i_s_axis_tlast;

    psf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_item   (in_item),
        .o_out_valid (q_valid),
        .i_out_ready (q_ready),
        .o_out_item  (q_item)
    );

    psf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out        (res)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - VALUE_W - COMP_W)'(0),
                             res.second_value, res.first_value};
    assign o_m_axis_tuser = {res.overflow, res.found};

endmodule

@@ design/psf_front.sv @@
module psf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psf_pkg::t_item i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output psf_pkg::t_item o_out_item
);
    import psf_pkg::*;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;

    logic push;
    logic pop;

    assign o_in_ready  = (r_fill != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_out_valid = (r_fill != '0);
    assign o_out_item  = r_q[r_rd_ptr];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + (QPTR_W + 1)'(1);
                2'b01:   r_fill <= r_fill - (QPTR_W + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ design/psf_back.sv @@
module psf_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [psf_pkg::VALUE_W-1:0] i_cfg_wdata,
    input  logic                     i_item_valid,
    output logic                     o_item_ready,
    input  psf_pkg::t_item           i_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output psf_pkg::t_result         o_out
);
    import psf_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_X_ADDR,
        S_X_DATA,
        S_SCAN,
        S_DONE
    } t_state;

    logic [VALUE_W-1:0] r_mem [CAPACITY];
    logic [VALUE_W-1:0] r_rd_data;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_drop;
    logic [ADDR_W-1:0]  r_i;
    logic [CNT_W-1:0]   r_j;
    logic               r_pend;
    logic [VALUE_W-1:0] r_x;
    logic [COMP_W-1:0]  r_c;
    logic               r_found;
    logic               r_out_valid;
    t_result            r_out;
    logic [VALUE_W-1:0] r_tgt;

    logic              item_take;
    logic              has_room;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [COMP_W-1:0] x_ext;
    logic [COMP_W-1:0] comp;
    logic              comp_ok;
    logic              hit;
    logic              last_i;
    logic              out_free;

    assign o_item_ready = (r_state == S_LOAD);
    assign item_take    = o_item_ready && i_item_valid;
    assign has_room     = (r_cnt < CNT_W'(CAPACITY));
    assign mem_we       = item_take && has_room;
    assign rd_addr      = (r_state == S_SCAN) ? r_j[ADDR_W-1:0] : r_i;

    assign x_ext   = {r_rd_data[VALUE_W-1], r_rd_data};
    assign comp    = {r_tgt[VALUE_W-1], r_tgt} - x_ext;
    // a complement outside the 32-bit range can never be in the store
    assign comp_ok = (comp[COMP_W-1] == comp[COMP_W-2]) && (comp != x_ext);
    assign hit     = r_pend && (r_rd_data == r_c[VALUE_W-1:0]);
    assign last_i  = ((CNT_W'(r_i) + CNT_W'(1)) == r_cnt);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_item.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_tgt       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tgt <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (item_take) begin
                        if (has_room) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_i     <= '0;
                            r_state <= S_X_ADDR;
                        end
                    end
                end
                S_X_ADDR: begin
                    r_state <= S_X_DATA;
                end
                S_X_DATA: begin
                    r_x <= r_rd_data;
                    r_c <= comp;
                    if (comp_ok) begin
                        r_j     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (last_i) begin
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + ADDR_W'(1);
                        r_state <= S_X_ADDR;
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, compared in the next cycle
                    if (hit) begin
                        r_found <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_j != r_cnt) begin
                        r_j    <= r_j + CNT_W'(1);
                        r_pend <= 1'b1;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                    end else if (last_i) begin
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + ADDR_W'(1);
                        r_state <= S_X_ADDR;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out.found        <= r_found;
                        r_out.overflow     <= r_drop;
                        r_out.first_value  <= r_found ? r_x : '0;
                        r_out.second_value <= r_found ? r_c : '0;
                        r_cnt              <= '0;
                        r_drop             <= 1'b0;
                        r_state            <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
